/* rtl/core/hba_pkg.sv */
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and constants of the handle bitmap allocator: geometry of the
// two-level bitmap, request and status codes, controller states and commands.
// ----------------------------------------------------------------------------
package hba_pkg;

  // Bitmap geometry (block size is a power of two)
  localparam int BLOCK_BITS   = 32;
  localparam int NUM_BLOCKS   = 64;
  localparam int RESERVED_LOW = 3;

  localparam int HANDLE_W = 11;
  localparam int WORD_W   = BLOCK_BITS;
  localparam int BIT_W    = $clog2(BLOCK_BITS);
  localparam int BLK_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int HBLK_W   = HANDLE_W - BIT_W;

  localparam logic [WORD_W-1:0] WORD_MASK     = '1;
  localparam logic [WORD_W-1:0] RESERVED_MASK =
    WORD_W'((64'd1 << RESERVED_LOW) - 64'd1);

  // Request codes
  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_QUERY   = 2'd2
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_MODIFY = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, pick target block, start word read
    logic commit;   // write back block word and flags, load result
  } dp_cmd_t;

endpackage

/* rtl/core/hba_ram.sv */
// ----------------------------------------------------------------------------
// hba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/hba_ctrl.sv */
// ----------------------------------------------------------------------------
// hba_ctrl
// Request sequencer: takes one transaction, runs the block word
// read-modify-write in the datapath and hands the result to the output stage.
// ----------------------------------------------------------------------------
module hba_ctrl import hba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_MODIFY;
        end
      end
      S_MODIFY: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on commit, drop when taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/hba_dp.sv */
// ----------------------------------------------------------------------------
// hba_dp
// Allocator datapath: per-block present and full flags, block word memory,
// first-qualifying-block and lowest-free-bit encoders, result registers.
// ----------------------------------------------------------------------------
module hba_dp import hba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  input  logic [1:0]          in_req_type,
  input  logic [HANDLE_W-1:0] in_handle_index,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_granted_index,
  output logic                out_is_used
);

  // Summary flags
  logic [NUM_BLOCKS-1:0] present_r, present_nxt;
  logic [NUM_BLOCKS-1:0] full_r, full_nxt;
  logic                  blk0_wr_r, blk0_wr_nxt;

  // Captured request
  logic [1:0]       req_r;
  logic [BIT_W-1:0] bit_r;
  logic [BLK_W-1:0] tgt_r;
  logic             absent_r, over_r, none_r;

  // Capture-side logic
  logic [HBLK_W-1:0]     hblk;
  logic [NUM_BLOCKS-1:0] qual;
  logic [BLK_W-1:0]      first_c, tgt_c;
  logic                  none_c, over_c, absent_c;

  // Modify-side logic
  logic [WORD_W-1:0] rd_data, word, sel, wdata;
  logic [BIT_W-1:0]  zpos;
  logic              we;
  status_t           status_c;
  logic [HANDLE_W-1:0] grant_c;
  logic              used_c;

  // Result registers
  logic [1:0]          out_status_r;
  logic [HANDLE_W-1:0] out_granted_index_r;
  logic                out_is_used_r;

  // Pick the target block: first absent or not-full block for allocate,
  // the handle's block otherwise
  assign hblk   = in_handle_index[HANDLE_W-1:BIT_W];
  assign over_c = 32'(hblk) >= 32'(NUM_BLOCKS);
  assign qual   = ~present_r | ~full_r;
  assign none_c = ~|qual;

  always_comb begin
    first_c = '0;
    for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
      if (qual[b]) begin
        first_c = BLK_W'(b);
      end
    end
  end

  assign tgt_c    = (in_req_type == REQ_ALLOC) ? first_c : BLK_W'(hblk);
  assign absent_c = !present_r[tgt_c];

  // Latch the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_req_type;
      bit_r    <= in_handle_index[BIT_W-1:0];
      tgt_r    <= tgt_c;
      absent_r <= absent_c;
      over_r   <= over_c;
      none_r   <= none_c;
    end
  end

  // Block word memory
  hba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.commit),
    .waddr (tgt_r),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (tgt_c),
    .rdata (rd_data)
  );

  // Block 0 reads as its reserved pattern until first written
  assign word = (tgt_r == '0 && !blk0_wr_r) ? RESERVED_MASK : rd_data;
  assign sel  = WORD_W'(1) << bit_r;

  // Lowest free bit of the block word
  always_comb begin
    zpos = '0;
    for (int i = BLOCK_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zpos = BIT_W'(i);
      end
    end
  end

  // Apply the request to the block word and the flags
  always_comb begin
    we          = 1'b0;
    wdata       = word;
    status_c    = ST_OK;
    grant_c     = '0;
    used_c      = 1'b0;
    present_nxt = present_r;
    full_nxt    = full_r;
    case (req_r)
      REQ_ALLOC: begin
        if (none_r) begin
          status_c = ST_FULL;
        end else if (absent_r) begin
          present_nxt[tgt_r] = 1'b1;
          we                 = 1'b1;
          wdata              = WORD_W'(1);
          full_nxt[tgt_r]    = (WORD_W'(1) == WORD_MASK);
          grant_c            = HANDLE_W'({tgt_r, BIT_W'(0)});
        end else begin
          we              = 1'b1;
          wdata           = word | (WORD_W'(1) << zpos);
          full_nxt[tgt_r] = (wdata == WORD_MASK);
          grant_c         = HANDLE_W'({tgt_r, zpos});
        end
      end
      REQ_RELEASE: begin
        if (over_r || absent_r) begin
          status_c = ST_BAD;
        end else begin
          we              = 1'b1;
          wdata           = word & ~sel;
          full_nxt[tgt_r] = 1'b0;
        end
      end
      REQ_QUERY: begin
        if (over_r) begin
          status_c = ST_BAD;
        end else if (!absent_r) begin
          used_c = |(word & sel);
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  assign blk0_wr_nxt = blk0_wr_r | (we && tgt_r == '0);

  // Flags advance on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= NUM_BLOCKS'(1);
      full_r       <= NUM_BLOCKS'(RESERVED_MASK == WORD_MASK);
      blk0_wr_r    <= 1'b0;
    end else if (cmd.commit) begin
      present_r    <= present_nxt;
      full_r       <= full_nxt;
      blk0_wr_r    <= blk0_wr_nxt;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r        <= status_c;
      out_granted_index_r <= grant_c;
      out_is_used_r       <= used_c;
    end
  end

  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_index_r;
  assign out_is_used       = out_is_used_r;

endmodule

/* rtl/core/handle_bitmap_allocator_unit.sv */
// An accepted transaction is captured, then committed, which loads the result
//   and sets out_valid. The next is taken only after the commit, due to the
//   read-modify-write of the chosen block word in the registered-read memory.
// A full output register stalls the modify step until the result is taken.
// Reset (synchronous, active low) marks only block 0 present and none full;
//   block 0 reads as its reserved pattern until first written. No clear pass.
// ----------------------------------------------------------------------------
// handle_bitmap_allocator_unit
// Two-level bitmap handle allocator: allocate, release and query handles.
// ----------------------------------------------------------------------------
module handle_bitmap_allocator_unit import hba_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [HANDLE_W-1:0] in_handle_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [HANDLE_W-1:0] out_granted_index,
  output logic                out_is_used
);

  dp_cmd_t cmd;

  // Sequencer
  hba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath
  hba_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_handle_index   (in_handle_index),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_is_used       (out_is_used)
  );

endmodule

/* rtl/core/hba_checker.sv */
// ----------------------------------------------------------------------------
// hba_checker
// Port-level checks of the allocator: stall behavior, one transaction in
// flight, and consistency of the result fields.
// ----------------------------------------------------------------------------
module hba_checker import hba_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_req_type,
  input logic [HANDLE_W-1:0] in_handle_index,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          out_status,
  input logic [HANDLE_W-1:0] out_granted_index,
  input logic                out_is_used
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_granted_index) && $stable(out_is_used))
    else $error("stalled result changed");

  // Drop ready after a transaction is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while one in flight");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_FULL || out_status == ST_BAD))
    else $error("undefined status code");

  // Failed request grants nothing and reports nothing in use
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_granted_index == '0 && !out_is_used)
    else $error("failed request carries data");

  // In-use answer never comes with a grant
  a_used_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_used |-> out_granted_index == '0)
    else $error("query result carries a grant");

endmodule

bind handle_bitmap_allocator_unit hba_checker u_hba_checker (.*);
